FILE: hw/rtl/stepper_can_command_framer_core_defines.svh
// Assertion macros shared by the framer RTL files.
`ifndef STEPPER_CAN_COMMAND_FRAMER_CORE_DEFINES_SVH
`define STEPPER_CAN_COMMAND_FRAMER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i and masked while rst_ni is low.
`define SCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and masked while rst_ni is low.
`define SCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/scf_pkg.sv
// Types and constants of the stepper CAN command framer.
package scf_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  localparam logic [7:0]  CheckByte  = 8'h6B;
  localparam logic [7:0]  FnVelocity = 8'hF6;
  localparam logic [7:0]  FnPosition = 8'hFB;
  localparam logic [7:0]  FnStop     = 8'hFE;
  localparam logic [7:0]  StopCode   = 8'h98;
  localparam logic [7:0]  FnHome     = 8'h9A;
  localparam logic [7:0]  MaxHoming  = 8'd3;
  localparam logic [15:0] MaxSpeedReset = 16'd40000;
  localparam logic [3:0]  LenLong    = 4'd8;
  localparam logic [3:0]  LenShort   = 4'd4;

  typedef enum logic [1:0] {
    ReqVelocity = 2'd0,
    ReqPosition = 2'd1,
    ReqStop     = 2'd2,
    ReqHome     = 2'd3
  } req_type_e;

  // One classified command waiting for the frame builder.
  typedef struct packed {
    logic        rejected;
    logic        two_frames;
    logic [7:0]  address;
    logic [3:0]  length;
    logic [63:0] payload;
    logic        absolute;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: hw/rtl/scf_cmd_if.sv
// Command request channel.
interface scf_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [7:0]         drive_address;
  logic signed [16:0] speed_tenths;
  logic [15:0]        ramp_rate;
  logic signed [32:0] position_tenths;
  logic               absolute_mode;
  logic [7:0]         homing_mode;

  modport source (output valid, req_type, drive_address, speed_tenths, ramp_rate,
                  position_tenths, absolute_mode, homing_mode, input ready);
  modport sink   (input valid, req_type, drive_address, speed_tenths, ramp_rate,
                  position_tenths, absolute_mode, homing_mode, output ready);
endinterface

FILE: hw/rtl/scf_frame_if.sv
// CAN frame request channel.
interface scf_frame_if;
  logic        valid;
  logic        ready;
  logic [15:0] can_identifier;
  logic [3:0]  frame_length;
  logic [63:0] frame_payload;
  logic        last_frame;
  logic        rejected;

  modport source (output valid, can_identifier, frame_length, frame_payload, last_frame,
                  rejected, input ready);
  modport sink   (input valid, can_identifier, frame_length, frame_payload, last_frame,
                  rejected, output ready);
endinterface

FILE: hw/rtl/stepper_can_command_framer_core.sv
// Top level of the stepper CAN command framer.
//
//   Channel   Direction  Handshake      Content
//   cmd_i     in         valid/ready    one motor command
//   frame_o   out        valid/ready    one CAN frame or a reject marker
//   cfg_*     in         write enable   max_speed_tenths
//
// A velocity, stop, home or rejected command gives one frame;
// a position command gives two frames and holds the frame builder until both are sent.
// An accepted command passes through the job queue and then the frame output register.
// Reset empties the two-entry job queue and sets the speed limit to 40000.
// The front end keeps accepting while the queue has room, so a stalled output
// blocks the input only once the queue is full.
module stepper_can_command_framer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  scf_cmd_if.sink     cmd_i,
  scf_frame_if.source frame_o
);
  import scf_pkg::*;

  job_t      push_job, head_job;
  q_status_t q_status;
  logic      push, pop;

  scf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (push_job)
  );

  scf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .head_o  (head_job),
    .status_o(q_status)
  );

  scf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head_job),
    .q_status_i(q_status),
    .pop_o     (pop),
    .frame_o   (frame_o)
  );

endmodule

FILE: hw/rtl/scf_front.sv
// Front end: speed limit register, command checks and first-frame payload build.
module scf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  scf_cmd_if.sink           cmd_i,
  input  scf_pkg::q_status_t q_status_i,
  output logic              push_o,
  output scf_pkg::job_t     job_o
);
  import scf_pkg::*;

  logic [15:0] max_speed_q, max_speed_d;
  req_type_e   kind;
  logic        sneg, pneg;
  logic [16:0] smag;
  logic [32:0] pmag_full;
  logic [31:0] pmag;
  logic        rej;

  always_comb begin
    max_speed_d = cfg_we_i ? cfg_wdata_i : max_speed_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= MaxSpeedReset;
    end else begin
      max_speed_q <= max_speed_d;
    end
  end

  always_comb begin
    kind = req_type_e'(cmd_i.req_type);
    sneg = cmd_i.speed_tenths[16];
    // The most negative speed comes out as 2^16 here and fails any limit.
    smag = sneg ? 17'(-cmd_i.speed_tenths) : 17'(cmd_i.speed_tenths);
    pneg = cmd_i.position_tenths[32];
    pmag_full = pneg ? 33'(-cmd_i.position_tenths) : 33'(cmd_i.position_tenths);
    pmag = pmag_full[32] ? 32'hFFFF_FFFF : pmag_full[31:0];

    rej = (cmd_i.drive_address == 8'd0)
       || (((kind == ReqVelocity) || (kind == ReqPosition)) && (smag > {1'b0, max_speed_q}))
       || ((kind == ReqPosition) && sneg)
       || ((kind == ReqHome) && (cmd_i.homing_mode > MaxHoming));

    job_o.rejected   = rej;
    job_o.two_frames = !rej && (kind == ReqPosition);
    job_o.address    = cmd_i.drive_address;
    job_o.absolute   = cmd_i.absolute_mode;
    case (kind)
      ReqVelocity: begin
        job_o.length  = LenLong;
        job_o.payload = {CheckByte, 8'h00, smag[7:0], smag[15:8],
                         cmd_i.ramp_rate[7:0], cmd_i.ramp_rate[15:8], 7'd0, sneg, FnVelocity};
      end
      ReqPosition: begin
        job_o.length  = LenLong;
        job_o.payload = {pmag[7:0], pmag[15:8], pmag[23:16], pmag[31:24],
                         smag[7:0], smag[15:8], 7'd0, pneg, FnPosition};
      end
      ReqStop: begin
        job_o.length  = LenShort;
        job_o.payload = {32'd0, CheckByte, 8'h00, StopCode, FnStop};
      end
      default: begin
        job_o.length  = LenShort;
        job_o.payload = {32'd0, CheckByte, 8'h00, cmd_i.homing_mode, FnHome};
      end
    endcase
  end

  assign cmd_i.ready = !q_status_i.full;
  assign push_o      = cmd_i.valid && !q_status_i.full;

endmodule

FILE: hw/rtl/scf_queue.sv
// Short job queue between the front end and the frame builder.
module scf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  scf_pkg::job_t      job_i,
  input  logic               pop_i,
  output scf_pkg::job_t      head_o,
  output scf_pkg::q_status_t status_o
);
  import scf_pkg::*;
  `include "stepper_can_command_framer_core_defines.svh"

  job_t            mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == CntW'(QueueDepth));
  assign status_o.empty = (count_q == '0);

  `SCF_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(QueueDepth), "queue count overflow")
  `SCF_ASSERT_NEXT(a_push_grows, push_i && !pop_i, count_q == CntW'($past(count_q) + 1'b1), "push lost")

endmodule

FILE: hw/rtl/scf_back.sv
// Back end: turns queued jobs into CAN frames held in an output register.
module scf_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scf_pkg::job_t      head_i,
  input  scf_pkg::q_status_t q_status_i,
  output logic               pop_o,
  scf_frame_if.source        frame_o
);
  import scf_pkg::*;
  `include "stepper_can_command_framer_core_defines.svh"

  logic        out_valid_q, out_valid_d;
  logic        second_q, second_d;
  logic [15:0] id_q, id_d;
  logic [3:0]  len_q, len_d;
  logic [63:0] payload_q, payload_d;
  logic        last_q, last_d;
  logic        rej_q, rej_d;
  logic        load, last_of_job;

  always_comb begin
    load        = !q_status_i.empty && (!out_valid_q || frame_o.ready);
    last_of_job = !head_i.two_frames || second_q;
    pop_o       = load && last_of_job;
    out_valid_d = load ? 1'b1 : (out_valid_q && !frame_o.ready);
    second_d    = load ? (head_i.two_frames && !second_q) : second_q;

    if (head_i.rejected) begin
      id_d      = '0;
      len_d     = '0;
      payload_d = '0;
      last_d    = 1'b0;
      rej_d     = 1'b1;
    end else if (second_q) begin
      // Closing frame of a position command: absolute flag and check byte.
      id_d      = {head_i.address, 8'd1};
      len_d     = LenShort;
      payload_d = {32'd0, CheckByte, 8'h00, 7'd0, head_i.absolute, FnPosition};
      last_d    = 1'b1;
      rej_d     = 1'b0;
    end else begin
      id_d      = {head_i.address, 8'd0};
      len_d     = head_i.length;
      payload_d = head_i.payload;
      last_d    = !head_i.two_frames;
      rej_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      second_q    <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      id_q      <= id_d;
      len_q     <= len_d;
      payload_q <= payload_d;
      last_q    <= last_d;
      rej_q     <= rej_d;
    end
  end

  assign frame_o.valid          = out_valid_q;
  assign frame_o.can_identifier = id_q;
  assign frame_o.frame_length   = len_q;
  assign frame_o.frame_payload  = payload_q;
  assign frame_o.last_frame     = last_q;
  assign frame_o.rejected       = rej_q;

  `SCF_ASSERT_NOW(a_second_has_job, second_q, !q_status_i.empty, "second frame without job")
  `SCF_ASSERT_NOW(a_reject_empty, out_valid_q && rej_q, (len_q == '0) && !last_q, "bad reject")
  `SCF_ASSERT_NEXT(a_second_follows,
                   frame_o.valid && frame_o.ready && !frame_o.last_frame && !frame_o.rejected,
                   frame_o.valid && frame_o.can_identifier[0], "second frame not next")

endmodule

FILE: verif/stepper_can_command_framer_core_tb.sv
// Self-checking testbench for the stepper CAN command framer core.
module stepper_can_command_framer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scf_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    req_type_e   kind;
    logic [7:0]  addr;
    logic [16:0] speed;
    logic [15:0] ramp;
    logic [32:0] angle;
    logic        absolute;
    logic [7:0]  homing;
  } motor_cmd_t;

  typedef struct packed {
    logic [15:0] id;
    logic [3:0]  len;
    logic [63:0] payload;
    logic        last;
    logic        rejected;
  } can_frame_t;

  typedef struct {
    motor_cmd_t cmd;
    bit         typed;
    can_frame_t frame;
  } stim_row_t;

  localparam can_frame_t RejectFrame = '{16'h0000, 4'd0, 64'h0, 1'b0, 1'b1};

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  scf_cmd_if   cmd_bus ();
  scf_frame_if frame_bus ();

  stepper_can_command_framer_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd_bus),
    .frame_o    (frame_bus)
  );

  logic [15:0]  speed_limit = MaxSpeedReset;
  can_frame_t   pending_frames[$];
  stim_row_t    directed_rows[$];
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  bit           gaps_on = 1'b1;
  bit           stall_request = 1'b0;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 40) begin
      $display("ERROR at %0t ns: %s", $realtime, msg);
    end
  endtask

  // Works out the frames that one accepted request must produce.
  function automatic void predict_frames(input motor_cmd_t c);
    logic        sneg;
    logic        aneg;
    logic [16:0] smag;
    logic [32:0] amag_full;
    logic [31:0] amag;
    can_frame_t  f;
    sneg = c.speed[16];
    smag = sneg ? -c.speed : c.speed;
    aneg = c.angle[32];
    amag_full = aneg ? -c.angle : c.angle;
    amag = amag_full[32] ? 32'hFFFF_FFFF : amag_full[31:0];
    if (c.addr == 8'd0 ||
        ((c.kind == ReqVelocity || c.kind == ReqPosition) && smag > {1'b0, speed_limit}) ||
        (c.kind == ReqPosition && sneg) ||
        (c.kind == ReqHome && c.homing > MaxHoming)) begin
      pending_frames.push_back(RejectFrame);
      return;
    end
    f.id = {c.addr, 8'h00};
    f.last = 1'b1;
    f.rejected = 1'b0;
    f.len = LenShort;
    case (c.kind)
      ReqVelocity: begin
        f.len = LenLong;
        f.payload = {CheckByte, 8'h00, smag[7:0], smag[15:8], c.ramp[7:0], c.ramp[15:8],
                     7'd0, sneg, FnVelocity};
      end
      ReqPosition: begin
        f.len = LenLong;
        f.last = 1'b0;
        f.payload = {amag[7:0], amag[15:8], amag[23:16], amag[31:24], smag[7:0], smag[15:8],
                     7'd0, aneg, FnPosition};
        pending_frames.push_back(f);
        f.id = {c.addr, 8'h01};
        f.len = LenShort;
        f.last = 1'b1;
        f.payload = {32'h0, CheckByte, 8'h00, 7'd0, c.absolute, FnPosition};
      end
      ReqStop: f.payload = {32'h0, CheckByte, 8'h00, StopCode, FnStop};
      default: f.payload = {32'h0, CheckByte, 8'h00, c.homing, FnHome};
    endcase
    pending_frames.push_back(f);
  endfunction

  function automatic motor_cmd_t make_cmd(input req_type_e kind, input logic [7:0] addr,
                                          input logic [16:0] speed, input logic [15:0] ramp,
                                          input logic [32:0] angle, input logic absolute,
                                          input logic [7:0] homing);
    motor_cmd_t c;
    c = '{kind, addr, speed, ramp, angle, absolute, homing};
    return c;
  endfunction

  function automatic void typed_row(input motor_cmd_t c, input can_frame_t f);
    directed_rows.push_back('{c, 1'b1, f});
  endfunction

  function automatic void checked_row(input motor_cmd_t c);
    directed_rows.push_back('{c, 1'b0, RejectFrame});
  endfunction

  function automatic motor_cmd_t random_cmd();
    motor_cmd_t  c;
    logic [15:0] mag;
    c.kind = req_type_e'($urandom_range(3));
    c.addr = ($urandom_range(19) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
    c.ramp = 16'($urandom);
    c.absolute = 1'($urandom);
    c.homing = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    mag = 16'($urandom_range(speed_limit));
    case ($urandom_range(11))
      0: c.speed = {1'b0, speed_limit};
      1: c.speed = {1'b0, speed_limit} + 17'd1;
      2: c.speed = -{1'b0, speed_limit};
      3: c.speed = 17'h10000;
      4: c.speed = 17'($urandom);
      default: begin
        c.speed = (c.kind != ReqPosition && $urandom_range(1) == 1) ? -{1'b0, mag}
                                                                     : {1'b0, mag};
      end
    endcase
    case ($urandom_range(9))
      0: c.angle = 33'h1_0000_0000;
      1: c.angle = 33'h0_FFFF_FFFF;
      2: c.angle = 33'h1_0000_0001;
      3: c.angle = 33'h0;
      default: c.angle = {1'($urandom), 32'($urandom)};
    endcase
    return c;
  endfunction

  // Valid stays high across back-to-back requests and is lowered only for a gap.
  task automatic send_cmd(input motor_cmd_t c, input bit typed, input can_frame_t f);
    if (gaps_on) begin
      while ($urandom_range(99) < 31) begin
        cmd_bus.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    cmd_bus.valid           <= 1'b1;
    cmd_bus.req_type        <= c.kind;
    cmd_bus.drive_address   <= c.addr;
    cmd_bus.speed_tenths    <= c.speed;
    cmd_bus.ramp_rate       <= c.ramp;
    cmd_bus.position_tenths <= c.angle;
    cmd_bus.absolute_mode   <= c.absolute;
    cmd_bus.homing_mode     <= c.homing;
    do @(posedge clk_i); while (!cmd_bus.ready);
    if (typed) begin
      pending_frames.push_back(f);
    end else begin
      predict_frames(c);
    end
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_cmd(random_cmd(), 1'b0, RejectFrame);
  endtask

  task automatic drain_frames();
    cmd_bus.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_speed_limit(input logic [15:0] value);
    drain_frames();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    speed_limit = value;
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin : frame_sink
    frame_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_request) begin
        stall_request = 1'b0;
        frame_bus.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else begin
        frame_bus.ready <= !gaps_on || ($urandom_range(99) >= 31);
      end
    end
  end

  always @(posedge clk_i) begin
    can_frame_t exp_frame;
    if (rst_ni && frame_bus.valid && frame_bus.ready) begin
      if (pending_frames.size() == 0) begin
        report_mismatch($sformatf("frame id %h with no request outstanding",
                                  frame_bus.can_identifier));
      end else begin
        exp_frame = pending_frames.pop_front();
        if (frame_bus.can_identifier !== exp_frame.id)
          report_mismatch($sformatf("can_identifier %h, expected %h",
                                    frame_bus.can_identifier, exp_frame.id));
        if (frame_bus.frame_length !== exp_frame.len)
          report_mismatch($sformatf("frame_length %0d, expected %0d",
                                    frame_bus.frame_length, exp_frame.len));
        if (frame_bus.frame_payload !== exp_frame.payload)
          report_mismatch($sformatf("frame_payload %h, expected %h",
                                    frame_bus.frame_payload, exp_frame.payload));
        if (frame_bus.last_frame !== exp_frame.last)
          report_mismatch($sformatf("last_frame %b, expected %b",
                                    frame_bus.last_frame, exp_frame.last));
        if (frame_bus.rejected !== exp_frame.rejected)
          report_mismatch($sformatf("rejected %b, expected %b",
                                    frame_bus.rejected, exp_frame.rejected));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    cmd_bus.valid           = 1'b0;
    cmd_bus.req_type        = ReqVelocity;
    cmd_bus.drive_address   = 8'd0;
    cmd_bus.speed_tenths    = 17'd0;
    cmd_bus.ramp_rate       = 16'd0;
    cmd_bus.position_tenths = 33'd0;
    cmd_bus.absolute_mode   = 1'b0;
    cmd_bus.homing_mode     = 8'd0;
    cfg_we_i                = 1'b0;
    cfg_wdata_i             = 16'd0;
    rst_ni                  = 1'b0;

    typed_row(make_cmd(ReqVelocity, 8'd0, 17'd100, 16'd10, 33'd0, 1'b0, 8'd0), RejectFrame);
    typed_row(make_cmd(ReqStop, 8'd1, 17'd0, 16'd0, 33'd0, 1'b0, 8'd0),
              '{16'h0100, LenShort, 64'h0000_0000_6B00_98FE, 1'b1, 1'b0});
    typed_row(make_cmd(ReqHome, 8'd255, 17'd0, 16'd0, 33'd0, 1'b0, 8'd3),
              '{16'hFF00, LenShort, 64'h0000_0000_6B00_039A, 1'b1, 1'b0});
    typed_row(make_cmd(ReqHome, 8'd5, 17'd0, 16'd0, 33'd0, 1'b0, 8'd4), RejectFrame);
    typed_row(make_cmd(ReqHome, 8'd5, 17'd0, 16'd0, 33'd0, 1'b0, 8'd255), RejectFrame);
    typed_row(make_cmd(ReqVelocity, 8'd7, 17'h10000, 16'd1, 33'd0, 1'b0, 8'd0), RejectFrame);
    typed_row(make_cmd(ReqVelocity, 8'd7, 17'd40001, 16'd1, 33'd0, 1'b0, 8'd0), RejectFrame);
    typed_row(make_cmd(ReqVelocity, 8'd7, -17'd40001, 16'd1, 33'd0, 1'b0, 8'd0), RejectFrame);
    typed_row(make_cmd(ReqPosition, 8'd9, -17'd1, 16'd0, 33'd10, 1'b1, 8'd0), RejectFrame);
    typed_row(make_cmd(ReqPosition, 8'd9, 17'd40001, 16'd0, 33'd10, 1'b1, 8'd0), RejectFrame);
    typed_row(make_cmd(ReqPosition, 8'd9, 17'd65535, 16'd0, 33'd10, 1'b1, 8'd0), RejectFrame);
    typed_row(make_cmd(ReqStop, 8'd0, 17'd0, 16'd0, 33'd0, 1'b0, 8'd0), RejectFrame);
    checked_row(make_cmd(ReqVelocity, 8'd255, 17'd40000, 16'hFFFF, 33'd0, 1'b0, 8'd0));
    checked_row(make_cmd(ReqVelocity, 8'd1, -17'd40000, 16'd0, 33'd0, 1'b1, 8'hFF));
    checked_row(make_cmd(ReqVelocity, 8'd128, 17'd0, 16'h8001, 33'h1_FFFF_FFFF, 1'b1, 8'd9));
    checked_row(make_cmd(ReqPosition, 8'd255, 17'd40000, 16'hFFFF, 33'h0_FFFF_FFFF, 1'b1,
                         8'd0));
    checked_row(make_cmd(ReqPosition, 8'd2, 17'd1, 16'd0, 33'h1_0000_0001, 1'b0, 8'd0));
    // The most negative angle saturates to the largest magnitude.
    checked_row(make_cmd(ReqPosition, 8'd3, 17'd123, 16'd0, 33'h1_0000_0000, 1'b1, 8'd0));
    checked_row(make_cmd(ReqPosition, 8'd4, 17'd0, 16'd0, 33'd0, 1'b0, 8'd0));
    checked_row(make_cmd(ReqStop, 8'h80, 17'h10000, 16'hFFFF, 33'h1_0000_0000, 1'b1, 8'hFF));
    checked_row(make_cmd(ReqHome, 8'h7F, 17'h1FFFF, 16'd0, 33'd0, 1'b1, 8'd0));
    checked_row(make_cmd(ReqHome, 8'h55, 17'd0, 16'd0, 33'd0, 1'b0, 8'd1));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].frame);
    end
    send_random(250);

    set_speed_limit(16'hFFFF);
    send_random(220);

    set_speed_limit(16'd0);
    send_random(140);

    set_speed_limit(16'd1);
    send_random(100);

    // A stretch without gaps on either side.
    set_speed_limit(16'($urandom));
    gaps_on = 1'b0;
    send_random(200);

    // The receiver holds off while requests keep coming, so the input stalls.
    set_speed_limit(16'd40000);
    stall_request = 1'b1;
    send_random(30);
    gaps_on = 1'b1;
    send_random(190);

    drain_frames();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
